@@ src/bsrs_pkg.sv @@
package bsrs_pkg;

    // requested rate register
    localparam int REQ_BITS          = 18;
    localparam int REQ_RESET         = 44100;

    // candidate rate width default
    localparam int RATE_BITS_DEF     = 20;

    // scoring weights
    localparam int DIST_WEIGHT       = 2;
    localparam int DOWNSCALE_PENALTY = 100;

    // divider control and status
    typedef struct packed {
        logic start;
    } t_div_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ src/best_sample_rate_select.sv @@
// best_sample_rate_select
//
// Searches a list of candidate sample rates for the one that best fits the
// requested rate. Candidates arrive on the s_axis channel, one per item, with
// tlast on the final one of the list. The user must set the requested rate
// through i_cfg_wr_en / i_cfg_wr_data while the block is idle (not enforced).
// Score = 2*|cand - req| + (larger mod smaller), times 100 when the candidate
// is below the request. Lowest score wins; the earliest wins a tie.
// Only the item carrying tlast produces a result on m_axis: the winning rate.
//
// Flow: s_axis_tready stays low from accept until the item is done, so a new
// item is taken only after the last one is through. Each item passes the
// serial restoring divider, one remainder bit per cycle, then the divider's
// done flag, scoring and the compare/update.
// The result is held in an output register. A stalled receiver does not block
// non-final items; a final item waits in its last step until the output
// register is free.
// Reset: the requested rate returns to 44100 and the search state is cleared.
module best_sample_rate_select
    import bsrs_pkg::*;
#(
    parameter int RATE_BITS = RATE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration: requested_rate
    input  logic                                i_cfg_wr_en,
    input  logic [REQ_BITS-1:0]                 i_cfg_wr_data,
    // candidate items
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((RATE_BITS+7)/8)*8-1:0]      s_axis_tdata,   // [RATE_BITS-1:0] candidate_rate
    input  logic                                s_axis_tlast,   // is_last
    // result items
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [((RATE_BITS+7)/8)*8-1:0]      m_axis_tdata    // [RATE_BITS-1:0] best_rate
);

    localparam int TDATA_BITS = ((RATE_BITS + 7) / 8) * 8;
    localparam int HI_BITS    = (RATE_BITS > REQ_BITS) ? RATE_BITS : REQ_BITS;
    localparam int BASE_BITS  = HI_BITS + 2;
    // below-request scores are bounded by the request width, others by the rate width
    localparam int SCORE_BITS = (RATE_BITS + 2 > REQ_BITS + 9) ? RATE_BITS + 2 : REQ_BITS + 9;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_SCORE = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [REQ_BITS-1:0]   r_req;
    logic [RATE_BITS-1:0]  r_cand;
    logic                  r_below;
    logic                  r_last;
    logic [HI_BITS-1:0]    r_dist;
    logic [SCORE_BITS-1:0] r_score;
    logic [SCORE_BITS-1:0] r_best_score;
    logic [RATE_BITS-1:0]  r_best_cand;
    logic                  r_have;
    logic                  r_out_valid;
    logic [RATE_BITS-1:0]  r_out_data;

    logic                  w_accept;
    logic [HI_BITS-1:0]    w_cand_x;
    logic [HI_BITS-1:0]    w_req_x;
    logic                  w_cand_gt;
    logic [HI_BITS-1:0]    w_hi;
    logic [HI_BITS-1:0]    w_lo;
    logic [BASE_BITS-1:0]  w_base;
    logic [SCORE_BITS-1:0] n_score;
    logic                  w_take;
    logic                  w_out_free;
    logic                  w_fin_go;

    t_div_ctrl             w_div_ctrl;
    t_div_stat             w_div_stat;
    logic [HI_BITS-1:0]    w_div_rem;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // operand setup from the incoming item
    always_comb begin
        w_cand_x  = HI_BITS'(s_axis_tdata[RATE_BITS-1:0]);
        w_req_x   = HI_BITS'(r_req);
        w_cand_gt = (w_cand_x > w_req_x);
        w_hi      = w_cand_gt ? w_cand_x : w_req_x;
        w_lo      = w_cand_gt ? w_req_x  : w_cand_x;
    end

    assign w_div_ctrl.start = w_accept;

    bsrs_div #(
        .W          (HI_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_div_ctrl),
        .i_dividend (w_hi),
        .i_divisor  (w_lo),
        .o_stat     (w_div_stat),
        .o_rem      (w_div_rem)
    );

    // score and compare
    always_comb begin
        w_base     = BASE_BITS'(r_dist) * BASE_BITS'(DIST_WEIGHT) + BASE_BITS'(w_div_rem);
        n_score    = r_below ? SCORE_BITS'(w_base) * SCORE_BITS'(DOWNSCALE_PENALTY)
                             : SCORE_BITS'(w_base);
        w_take     = !r_have || (r_score < r_best_score);
        w_out_free = !r_out_valid || m_axis_tready;
        w_fin_go   = !r_last || w_out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_stat.done) n_state = ST_SCORE;
            end
            ST_SCORE: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (w_fin_go) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_req        <= REQ_BITS'(REQ_RESET);
            r_have       <= 1'b0;
            r_best_score <= '0;
            r_best_cand  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) r_req <= i_cfg_wr_data;

            // a new winner refills the output register as the old one leaves
            if ((r_state == ST_FIN) && w_fin_go && r_last) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if ((r_state == ST_FIN) && w_fin_go) begin
                if (r_last) begin
                    // emit winner, start a fresh list
                    r_have       <= 1'b0;
                    r_best_score <= '0;
                    r_best_cand  <= '0;
                end else if (w_take) begin
                    r_have       <= 1'b1;
                    r_best_score <= r_score;
                    r_best_cand  <= r_cand;
                end
            end
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cand  <= s_axis_tdata[RATE_BITS-1:0];
            r_last  <= s_axis_tlast;
            r_below <= (w_cand_x < w_req_x);
            r_dist  <= w_hi - w_lo;
        end
        if (r_state == ST_SCORE) r_score <= n_score;
        if ((r_state == ST_FIN) && r_last && w_out_free) begin
            r_out_data <= w_take ? r_cand : r_best_cand;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_BITS'(r_out_data);

endmodule

@@ src/bsrs_div.sv @@
module bsrs_div
    import bsrs_pkg::*;
#(
    parameter int W = RATE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_div_ctrl    i_ctrl,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output t_div_stat    o_stat,
    output logic [W-1:0] o_rem
);

    localparam int CNT_BITS = (W > 1) ? $clog2(W) : 1;

    logic [W-1:0]        r_dvd;
    logic [W-1:0]        r_dvs;
    logic [W-1:0]        r_rem;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [W:0]          w_trial;
    logic [W:0]          w_diff;
    logic                w_fits;
    logic [W-1:0]        n_rem;

    // one restoring step per cycle; a zero divisor leaves the dividend as remainder
    always_comb begin
        w_trial = {r_rem, r_dvd[W-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        w_fits  = (w_trial >= {1'b0, r_dvs});
        n_rem   = w_fits ? w_diff[W-1:0] : w_trial[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

endmodule

@@ src/bsrs_chk.sv @@
module bsrs_chk #(
    parameter int TDATA_BITS = 24
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [TDATA_BITS-1:0] m_axis_tdata
);

    logic w_in_acc;
    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    // an accepted item keeps s_axis_tready low after the accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input ready too soon after an accepted item");

    // a result never appears the cycle right after an accept
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !$rose(m_axis_tvalid))
        else $error("result raised right after accept");

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind best_sample_rate_select bsrs_chk #(
    .TDATA_BITS    (TDATA_BITS)
) u_bsrs_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ dv/best_sample_rate_select_tb.sv @@
module best_sample_rate_select_tb;
    import bsrs_pkg::*;

    // tdata width of both streams: candidate / best rate padded to whole bytes
    localparam int TDW         = ((RATE_BITS_DEF + 7) / 8) * 8;
    // cycles to let a non-final item finish scoring before touching the register
    localparam int IDLE_GAP    = 40;
    localparam int N_RANDOM    = 800;
    localparam int LONG_HOLD   = 400;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [RATE_BITS_DEF-1:0] rate;
        logic                     last;
    } t_cand_item;

    // ------------------------------------------------------------------
    // DUT ports; every driven input starts at a known value
    // ------------------------------------------------------------------
    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_cfg_wr_en    = 1'b0;
    logic [REQ_BITS-1:0] i_cfg_wr_data  = '0;
    logic                s_axis_tvalid  = 1'b0;
    logic                s_axis_tready;
    logic [TDW-1:0]      s_axis_tdata   = '0;   // [19:0] candidate_rate
    logic                s_axis_tlast   = 1'b0; // is_last
    logic                m_axis_tvalid;
    logic                m_axis_tready  = 1'b0;
    logic [TDW-1:0]      m_axis_tdata;          // [19:0] best_rate

    best_sample_rate_select #(
        .RATE_BITS (RATE_BITS_DEF)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    t_cand_item               pend_q[$];      // candidates waiting for the driver
    logic [RATE_BITS_DEF-1:0] best_rate_q[$]; // predicted winners, oldest first
    int                       n_errors  = 0;
    int                       n_results = 0;
    logic                     in_fire   = 1'b0; // candidate taken at the last rising edge

    // predictor copy of the register and the running search
    logic [REQ_BITS-1:0]      req_rate   = REQ_BITS'(REQ_RESET);
    logic [27:0]              srch_score = '0;
    logic [RATE_BITS_DEF-1:0] srch_rate  = '0;
    logic                     srch_valid = 1'b0;

    // value last written by the stimulus, used to aim candidates near the request
    logic [REQ_BITS-1:0]      req_now = REQ_BITS'(REQ_RESET);

    int unsigned std_rates [15] = '{8000, 11025, 16000, 22050, 32000, 44100, 48000,
                                    88200, 96000, 176400, 192000, 352800, 384000,
                                    705600, 768000};

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    // 2*|c - r| + (hi mod lo), x100 below the request; lo == 0 leaves hi as the
    // remainder, like the restoring divider
    function automatic logic [27:0] fit_score(logic [RATE_BITS_DEF-1:0] cand,
                                              logic [REQ_BITS-1:0] req);
        longint unsigned c, r, hi, lo, rem, s;
        c   = cand;
        r   = req;
        hi  = (c > r) ? c : r;
        lo  = (c > r) ? r : c;
        rem = (lo == 0) ? hi : (hi % lo);
        s   = (hi - lo) * DIST_WEIGHT + rem;
        if (c < r)
            s = s * DOWNSCALE_PENALTY;
        return s[27:0];
    endfunction

    // fold one accepted candidate into the search; tlast queues the winner
    task automatic absorb_candidate(logic [RATE_BITS_DEF-1:0] cand, logic last);
        logic [27:0] sc;
        sc = fit_score(cand, req_rate);
        // strict compare: the earliest candidate keeps a tie
        if (!srch_valid || sc < srch_score) begin
            srch_score = sc;
            srch_rate  = cand;
            srch_valid = 1'b1;
        end
        if (last) begin
            best_rate_q.push_back(srch_rate);
            srch_score = '0;
            srch_rate  = '0;
            srch_valid = 1'b0;
        end
    endtask

    task automatic note_error(string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("ERROR: %s", msg);
    endtask

    // ------------------------------------------------------------------
    // Rising edge: register shadow, predictor, result check
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (i_cfg_wr_en)
                req_rate = i_cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready)
                absorb_candidate(s_axis_tdata[RATE_BITS_DEF-1:0], s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                if (best_rate_q.size() == 0) begin
                    note_error($sformatf("unexpected result best_rate=%0d",
                                         m_axis_tdata[RATE_BITS_DEF-1:0]));
                end else begin
                    logic [RATE_BITS_DEF-1:0] want;
                    want = best_rate_q.pop_front();
                    if (m_axis_tdata[RATE_BITS_DEF-1:0] !== want)
                        note_error($sformatf("best_rate expected %0d actual %0d", want,
                                             m_axis_tdata[RATE_BITS_DEF-1:0]));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Candidate driver: bursts of random length, random gaps in between
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pend_q.size() != 0) begin
                t_cand_item it;
                it = pend_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= TDW'(it.rate);
                s_axis_tlast  <= it.last;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    // a quarter of the bursts run back to back
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: the stall pattern switches among random modes at random intervals.
    // Twice it holds off for a long stretch while plenty of candidates are
    // still queued, so a held result backs up into the input.
    // ------------------------------------------------------------------
    int hold_left = 0;
    int hold_at   = 15;
    int pat_mode  = 0;
    int pat_left  = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (n_results >= hold_at && pend_q.size() > 20) begin
            hold_left = LONG_HOLD;
            hold_at   = (hold_at < 150) ? 150 : 32'h7fff_ffff;
            m_axis_tready <= 1'b0;
        end else begin
            if (pat_left <= 0) begin
                pat_mode = $urandom_range(0, 3);
                pat_left = $urandom_range(20, 200);
            end
            pat_left--;
            case (pat_mode)
                0: begin
                    m_axis_tready <= 1'b1;
                end
                1: begin
                    m_axis_tready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    m_axis_tready <= ($urandom_range(0, 7) == 0);
                end
                default: begin
                    m_axis_tready <= ~m_axis_tready;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_cand(logic [RATE_BITS_DEF-1:0] rate, logic last);
        t_cand_item it;
        it.rate = rate;
        it.last = last;
        pend_q.push_back(it);
    endtask

    // sender stops until every winner is out and the block is ready again,
    // then lets a non-final item finish
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pend_q.size() != 0 || s_axis_tvalid || best_rate_q.size() != 0
               || !s_axis_tready);
        repeat (IDLE_GAP) @(negedge i_clk);
    endtask

    task automatic write_req(logic [REQ_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        req_now       = value;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    function automatic logic [REQ_BITS-1:0] pick_req();
        case ($urandom_range(0, 7))
            0, 1:    return REQ_BITS'(std_rates[$urandom_range(0, 10)]);
            2:       return REQ_BITS'($urandom_range(1, 192000));
            3:       return REQ_BITS'($urandom);
            4:       return REQ_BITS'($urandom_range(1, 40));
            5:       return '1;
            6:       return '0;
            default: return REQ_BITS'($urandom_range(1, 1000));
        endcase
    endfunction

    function automatic logic [RATE_BITS_DEF-1:0] rand_candidate(logic [REQ_BITS-1:0] req);
        int unsigned r;
        r = req;
        case ($urandom_range(0, 11))
            0, 1, 2: return RATE_BITS_DEF'(std_rates[$urandom_range(0, 14)]);
            3:       return RATE_BITS_DEF'($urandom);
            4:       return RATE_BITS_DEF'(r + $urandom_range(0, 50));
            5:       return RATE_BITS_DEF'(r - $urandom_range(0, 50));
            6:       return RATE_BITS_DEF'(r * $urandom_range(1, 4));
            7:       return RATE_BITS_DEF'(r / $urandom_range(1, 4));
            8:       return RATE_BITS_DEF'($urandom_range(1, 768000));
            9:       return RATE_BITS_DEF'($urandom_range(0, 64));
            10:      return ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: return RATE_BITS_DEF'(r + $urandom_range(0, 2000) - 1000);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        int n_random;
        int stop_at;
        int len;
        int drain;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // -- directed: register at its reset value first
        push_cand(20'd48000, 1'b0);
        push_cand(20'd96000, 1'b0);
        push_cand(20'd22050, 1'b0);
        push_cand(20'd44100, 1'b1);      // exact match wins
        push_cand(20'd0, 1'b1);          // zero candidate: remainder is the request
        push_cand('1, 1'b1);             // largest field value
        push_cand(20'd32000, 1'b0);
        push_cand(20'd48000, 1'b1);      // upscale beats a farther downscale
        push_cand(20'd48000, 1'b0);
        push_cand(20'd48000, 1'b1);      // tie keeps the first
        push_cand(20'd96000, 1'b0);      // list left open across a register write
        wait_idle();
        write_req('0);                   // zero request: every remainder is the candidate
        push_cand(20'd0, 1'b1);          // both zero: score zero
        push_cand(20'd5, 1'b0);
        push_cand(20'd3, 1'b1);
        wait_idle();
        write_req('1);
        push_cand(20'd262143, 1'b0);
        push_cand('1, 1'b0);
        push_cand(20'd1, 1'b1);
        wait_idle();
        write_req(18'd1);
        push_cand(20'd1, 1'b0);
        push_cand(20'd2, 1'b1);
        wait_idle();
        write_req(18'd192000);
        push_cand(20'd176400, 1'b0);
        push_cand(20'd192000, 1'b1);
        wait_idle();

        // -- random phases: new request, then a burst of lists.
        // Some phases end mid-list so the next request scores the remainder.
        n_random = 0;
        while (n_random < N_RANDOM) begin
            write_req(pick_req());
            stop_at = n_random + $urandom_range(40, 140);
            while (n_random < stop_at) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16)
                                                  : $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    push_cand(rand_candidate(req_now), i == len - 1);
                    n_random++;
                end
            end
            if ($urandom_range(0, 2) == 0) begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++) begin
                    push_cand(rand_candidate(req_now), 1'b0);
                    n_random++;
                end
            end
            wait_idle();
        end
        push_cand(rand_candidate(req_now), 1'b1);

        // -- drain: everything sent, every winner back, then a little slack
        drain = 0;
        while ((pend_q.size() != 0 || s_axis_tvalid || best_rate_q.size() != 0)
               && drain < 20000) begin
            @(negedge i_clk);
            drain++;
        end
        repeat (IDLE_GAP) @(negedge i_clk);
        while (best_rate_q.size() != 0)
            note_error($sformatf("missing result best_rate=%0d", best_rate_q.pop_front()));

        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
src/bsrs_pkg.sv
src/bsrs_div.sv
src/best_sample_rate_select.sv
src/bsrs_chk.sv
dv/best_sample_rate_select_tb.sv
